// ===== hw/rtl/rkd_pkg.sv =====
// shared types, constants and the quadrature table for the rotary knob decoder
package rkd_pkg;

  localparam int unsigned TIME_BITS_DEFAULT = 32;
  localparam int unsigned POS_BITS_DEFAULT  = 32;

  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 2;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] CFG_STEPS_LOG2    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_MS   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS_MS = 2'd2;

  localparam logic [1:0]  STEPS_LOG2_RESET    = 2'd2;
  localparam logic [15:0] DEBOUNCE_MS_RESET   = 16'd200;
  localparam logic [15:0] LONG_PRESS_MS_RESET = 16'd8000;

  localparam logic [1:0]  STEPS_LOG2_MAX = 2'd2;
  localparam logic [1:0]  AB_IDLE        = 2'b11;

  typedef struct packed {
    logic a_level;
    logic b_level;
    logic sw_level;
    logic tick;
    logic take_delta;
    logic take_press;
    logic take_long;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] raw_position;
    logic signed [31:0] detent_position;
    logic signed [31:0] pending_delta;
    logic               press_pending;
    logic               long_pending;
    logic        [31:0] last_rock_ms;
    logic        [31:0] last_rock_gap_ms;
    logic        [31:0] held_ms;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  steps_log2;
    logic [15:0] debounce_ms;
    logic [15:0] hold_limit_ms;
  } cfg_t;

  // step for {prev_ab, ab}
  function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
    logic signed [1:0] step;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: step = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: step = 2'sd1;
      default: step = 2'sd0;
    endcase
    return step;
  endfunction

endpackage

// ===== hw/rtl/rkd_engine.sv =====
// decoder state and the per-request update: quadrature, detents, rock stamps, switch
module rkd_engine #(
  parameter int unsigned TIME_BITS = rkd_pkg::TIME_BITS_DEFAULT,
  parameter int unsigned POS_BITS  = rkd_pkg::POS_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  rkd_pkg::in_item_t item,
  input  rkd_pkg::cfg_t     cfg,
  output rkd_pkg::out_item_t result
);

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_LEFT  = 2'd2
  } dir_t;

  logic [TIME_BITS-1:0]       clock_ms;
  logic [1:0]                 prev_ab;
  logic signed [POS_BITS-1:0] step_count;
  logic signed [POS_BITS-1:0] last_detent;
  logic [31:0]                delta_accum;
  dir_t                       last_direction;
  logic [TIME_BITS-1:0]       last_direction_ms;
  logic [TIME_BITS-1:0]       rock_stamp;
  logic [TIME_BITS-1:0]       rock_gap;
  logic                       press_flag;
  logic                       long_flag;
  logic [TIME_BITS-1:0]       switch_edge_ms;
  logic                       switch_accepted;
  logic                       switch_prev_sample;
  logic [TIME_BITS-1:0]       press_start_ms;
  logic                       long_done;

  logic [TIME_BITS-1:0]       clock_ms_next;
  logic [1:0]                 ab;
  logic signed [POS_BITS-1:0] step_count_next;
  logic [TIME_BITS-1:0]       edge_age;
  logic                       press_ok;
  logic [TIME_BITS-1:0]       switch_edge_ms_next;
  logic                       switch_accepted_next;
  logic                       press_flag_next;
  logic [TIME_BITS-1:0]       press_start_ms_next;
  logic                       long_done_next;
  logic                       long_fire;
  logic                       long_flag_next;
  logic [1:0]                 shift;
  logic [1:0]                 bias;
  logic signed [POS_BITS-1:0] biased;
  logic signed [POS_BITS-1:0] detent;
  logic signed [POS_BITS:0]   delta;
  logic                       moved;
  dir_t                       dir;
  logic [31:0]                delta_accum_next;
  logic [TIME_BITS-1:0]       rock_stamp_next;
  logic [TIME_BITS-1:0]       rock_gap_next;
  logic [TIME_BITS-1:0]       held_age;

  assign clock_ms_next   = item.tick ? clock_ms + 1'b1 : clock_ms;
  assign ab              = {item.a_level, item.b_level};
  assign step_count_next = step_count + POS_BITS'(rkd_pkg::quad_step({prev_ab, ab}));

  // switch debounce: release at once, press only after the quiet time
  assign edge_age = clock_ms_next - switch_edge_ms;
  assign press_ok = edge_age >= TIME_BITS'(cfg.debounce_ms);

  always_comb begin
    switch_edge_ms_next  = switch_edge_ms;
    switch_accepted_next = switch_accepted;
    press_flag_next      = press_flag;
    press_start_ms_next  = press_start_ms;
    long_done_next       = long_done;
    if (item.sw_level != switch_prev_sample) begin
      if (item.sw_level) begin
        switch_accepted_next = 1'b1;
        switch_edge_ms_next  = clock_ms_next;
      end else if (press_ok) begin
        switch_edge_ms_next  = clock_ms_next;
        switch_accepted_next = 1'b0;
        press_flag_next      = 1'b1;
        press_start_ms_next  = clock_ms_next;
        long_done_next       = 1'b0;
      end
    end
  end

  // detent = raw / 2^shift toward zero: bias negatives before the arithmetic shift
  assign shift = (cfg.steps_log2 > rkd_pkg::STEPS_LOG2_MAX) ? rkd_pkg::STEPS_LOG2_MAX
                                                            : cfg.steps_log2;
  always_comb begin
    case (shift)
      2'd0:    bias = 2'd0;
      2'd1:    bias = 2'd1;
      default: bias = 2'd3;
    endcase
  end

  assign biased = step_count_next +
                  $signed({{(POS_BITS-2){1'b0}}, (step_count_next[POS_BITS-1] ? bias : 2'd0)});
  assign detent = biased >>> shift;
  assign delta  = (POS_BITS+1)'(detent) - (POS_BITS+1)'(last_detent);
  assign moved  = (detent != last_detent);
  assign dir    = delta[POS_BITS] ? DIR_LEFT : DIR_RIGHT;

  always_comb begin
    delta_accum_next = delta_accum;
    rock_stamp_next  = rock_stamp;
    rock_gap_next    = rock_gap;
    if (moved) begin
      delta_accum_next = delta_accum + 32'(delta);
      if (last_direction == DIR_LEFT && dir == DIR_RIGHT) begin
        rock_gap_next   = clock_ms_next - last_direction_ms;
        rock_stamp_next = (clock_ms_next == '0) ? TIME_BITS'(1) : clock_ms_next;
      end
    end
  end

  // long press fires once per hold
  assign held_age       = clock_ms_next - press_start_ms_next;
  assign long_fire      = !switch_accepted_next && !long_done_next &&
                          held_age >= TIME_BITS'(cfg.hold_limit_ms);
  assign long_flag_next = long_flag || long_fire;

  always_comb begin
    result.raw_position     = 32'(step_count_next);
    result.detent_position  = 32'(detent);
    result.pending_delta    = delta_accum_next;
    result.press_pending    = press_flag_next;
    result.long_pending     = long_flag_next;
    result.last_rock_ms     = 32'(rock_stamp_next);
    result.last_rock_gap_ms = 32'(rock_gap_next);
    result.held_ms          = switch_accepted_next ? 32'd0 : 32'(held_age);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_ms           <= '0;
      prev_ab            <= rkd_pkg::AB_IDLE;
      step_count         <= '0;
      last_detent        <= '0;
      delta_accum        <= '0;
      last_direction     <= DIR_NONE;
      last_direction_ms  <= '0;
      rock_stamp         <= '0;
      rock_gap           <= '0;
      press_flag         <= 1'b0;
      long_flag          <= 1'b0;
      switch_edge_ms     <= '0;
      switch_accepted    <= 1'b1;
      switch_prev_sample <= 1'b1;
      press_start_ms     <= '0;
      long_done          <= 1'b0;
    end else if (advance) begin
      clock_ms           <= clock_ms_next;
      prev_ab            <= ab;
      step_count         <= step_count_next;
      last_detent        <= detent;
      delta_accum        <= item.take_delta ? 32'd0 : delta_accum_next;
      if (moved) begin
        last_direction    <= dir;
        last_direction_ms <= clock_ms_next;
      end
      rock_stamp         <= rock_stamp_next;
      rock_gap           <= rock_gap_next;
      press_flag         <= item.take_press ? 1'b0 : press_flag_next;
      long_flag          <= item.take_long ? 1'b0 : long_flag_next;
      switch_edge_ms     <= switch_edge_ms_next;
      switch_accepted    <= switch_accepted_next;
      switch_prev_sample <= item.sw_level;
      press_start_ms     <= press_start_ms_next;
      long_done          <= long_done_next || long_fire;
    end
  end

endmodule

// ===== hw/rtl/rotary_knob_decoder_unit.sv =====
// rotary knob decoder top level: input register, decoder state update, result register
//
// Takes one request per clock while the output is not stalled, and returns exactly one
// result per request, valid on the output once it is written into the result register.
// The request sits in an input register; the decoder state is updated as it moves into
// the result register, so a full rate of one request per cycle is held as long as results
// are taken. Configuration writes take effect from the next cycle and should only be made
// while no request is in flight.
module rotary_knob_decoder_unit #(
  parameter int unsigned TIME_BITS = rkd_pkg::TIME_BITS_DEFAULT,
  parameter int unsigned POS_BITS  = rkd_pkg::POS_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rkd_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rkd_pkg::out_item_t                  out_data,
  input  logic                                cfg_wr_en,
  input  logic [rkd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rkd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  logic               hold_valid;
  rkd_pkg::in_item_t  hold_item;
  logic               advance;
  logic               in_take;
  rkd_pkg::cfg_t      cfg;
  rkd_pkg::out_item_t result;

  assign advance  = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_take) begin
        hold_valid <= 1'b1;
      end else if (advance) begin
        hold_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_item <= in_data;
    end
    if (advance) begin
      out_data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.steps_log2    <= rkd_pkg::STEPS_LOG2_RESET;
      cfg.debounce_ms   <= rkd_pkg::DEBOUNCE_MS_RESET;
      cfg.hold_limit_ms <= rkd_pkg::LONG_PRESS_MS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rkd_pkg::CFG_STEPS_LOG2:    cfg.steps_log2    <= cfg_wdata[1:0];
        rkd_pkg::CFG_DEBOUNCE_MS:   cfg.debounce_ms   <= cfg_wdata;
        rkd_pkg::CFG_LONG_PRESS_MS: cfg.hold_limit_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rkd_engine #(
    .TIME_BITS(TIME_BITS),
    .POS_BITS (POS_BITS)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .advance(advance),
    .item   (hold_item),
    .cfg    (cfg),
    .result (result)
  );

endmodule
